// ===== src/perspective_world_to_screen_macros.svh =====
// ============================================================================
// Perspective World To Screen Assertion Macros
// Concurrent assertion shorthands shared by the checker files.
// ============================================================================
`ifndef PERSPECTIVE_WORLD_TO_SCREEN_MACROS_SVH
`define PERSPECTIVE_WORLD_TO_SCREEN_MACROS_SVH

// clocked property, masked while reset is high
`define PWS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked during reset as well
`define PWS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pws_pkg.sv =====
// ============================================================================
// Perspective World To Screen Package
// Shared widths, codes and the control bundle of the projection pipeline.
// ============================================================================
`default_nettype none

package pws_pkg;

   localparam int COEF_W    = 32;
   localparam int NUM_COEF  = 12;
   localparam int IDX_W     = 4;
   localparam int DIM_W     = 14;
   localparam int CSR_IDX_W = 1;
   localparam int NQ_W      = 47;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_PROJECT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 14'd1920;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd1080;

   typedef struct packed {
      logic valid;
      logic w_zero;
      logic dw_clip;
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
   } pws_ctl_type;

endpackage

`default_nettype wire

// ===== src/pws_if.sv =====
// ============================================================================
// Perspective World To Screen Channels
// Request and response valid/ready channels with their payloads.
// ============================================================================
`default_nettype none

interface pws_req_if;
   import pws_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [IDX_W-1:0]         coef_index;
   logic signed [COEF_W-1:0] coef_value;
   logic signed [COEF_W-1:0] point_x;
   logic signed [COEF_W-1:0] point_y;
   logic signed [COEF_W-1:0] point_z;
   modport source(output valid, op, coef_index, coef_value, point_x, point_y, point_z,
                  input ready);
   modport sink(input valid, op, coef_index, coef_value, point_x, point_y, point_z,
                output ready);
endinterface

interface pws_rsp_if;
   import pws_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] screen_x;
   logic signed [COEF_W-1:0] screen_y;
   logic signed [COEF_W-1:0] depth_w;
   logic                     w_zero;
   logic                     clipped;
   modport source(output valid, screen_x, screen_y, depth_w, w_zero, clipped, input ready);
   modport sink(input valid, screen_x, screen_y, depth_w, w_zero, clipped, output ready);
endinterface

`default_nettype wire

// ===== src/perspective_world_to_screen.sv =====
// ============================================================================
// Perspective World To Screen
// Fixed-point projection of world points to viewport pixels.
//
//   channel  | dir | handshake        | carries
//   req_port | in  | valid/ready      | op, coef_index, coef_value, point_x/y/z
//   rsp_port | out | valid/ready      | screen_x, screen_y, depth_w, w_zero, clipped
//   csr_*    | in  | write enable     | screen_width (0), screen_height (1)
//
// One item enters per cycle unless rsp_port stalls; the pipeline is 29 register stages
// deep between acceptance on req_port and rsp_port. The depth is set by the 24-stage
// quotient pipeline (two bits a stage) plus two dot product, one setup and two
// viewport stages. Load items update the coefficients at acceptance.
// Reset clears the coefficients and restores 1920x1080; no clearing pass.
// A stalled response freezes every stage; req_port.ready follows it directly.
// ============================================================================
`default_nettype none

module perspective_world_to_screen #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pws_req_if.sink                              req_port,
   pws_rsp_if.source                            rsp_port,
   input  logic                                 csr_we,
   input  logic [pws_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pws_pkg::DIM_W-1:0]            csr_wdata
);
   import pws_pkg::*;

   localparam int CLIP_W = 66 - FRAC_BITS;

   logic                     adv, accept;
   logic [DIM_W-1:0]         width_ff, height_ff;
   logic                     dot_valid;
   logic signed [CLIP_W-1:0] cx, cy, cw;
   pws_ctl_type              div_ctl;
   logic [NQ_W-1:0]          quo_x, quo_y;
   logic signed [COEF_W-1:0] div_dw;

   assign adv            = !rsp_port.valid || rsp_port.ready;
   assign req_port.ready = adv;
   assign accept         = req_port.valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   pws_dot #(.FRAC_BITS(FRAC_BITS), .CLIP_W(CLIP_W)) u_dot (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .load_we    (accept && req_port.op == OP_LOAD),
      .load_idx   (req_port.coef_index),
      .load_value (req_port.coef_value),
      .in_valid   (accept && req_port.op == OP_PROJECT),
      .px         (req_port.point_x),
      .py         (req_port.point_y),
      .pz         (req_port.point_z),
      .out_valid  (dot_valid),
      .cx         (cx),
      .cy         (cy),
      .cw         (cw)
   );

   pws_div #(.FRAC_BITS(FRAC_BITS), .CLIP_W(CLIP_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (dot_valid),
      .num_x    (cx),
      .num_y    (cy),
      .den      (cw),
      .out_ctl  (div_ctl),
      .quo_x    (quo_x),
      .quo_y    (quo_y),
      .out_dw   (div_dw)
   );

   pws_map #(.FRAC_BITS(FRAC_BITS)) u_map (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_ctl    (div_ctl),
      .quo_x     (quo_x),
      .quo_y     (quo_y),
      .in_dw     (div_dw),
      .width     (width_ff),
      .height    (height_ff),
      .out_valid (rsp_port.valid),
      .screen_x  (rsp_port.screen_x),
      .screen_y  (rsp_port.screen_y),
      .depth_w   (rsp_port.depth_w),
      .w_zero    (rsp_port.w_zero),
      .clipped   (rsp_port.clipped)
   );

endmodule

`default_nettype wire

// ===== src/pws_dot.sv =====
// ============================================================================
// Perspective World To Screen Dot Products
// Coefficient store and two-stage clip x, y, w dot product pipeline.
// ============================================================================
`default_nettype none

module pws_dot #(
   parameter int FRAC_BITS = 16,
   parameter int CLIP_W    = 66 - FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              load_we,
   input  logic [pws_pkg::IDX_W-1:0]         load_idx,
   input  logic signed [pws_pkg::COEF_W-1:0] load_value,
   input  logic                              in_valid,
   input  logic signed [pws_pkg::COEF_W-1:0] px,
   input  logic signed [pws_pkg::COEF_W-1:0] py,
   input  logic signed [pws_pkg::COEF_W-1:0] pz,
   output logic                              out_valid,
   output logic signed [CLIP_W-1:0]          cx,
   output logic signed [CLIP_W-1:0]          cy,
   output logic signed [CLIP_W-1:0]          cw
);
   import pws_pkg::*;

   localparam int PROD_W = 2 * COEF_W;
   localparam int SH_W   = PROD_W - FRAC_BITS;

   logic signed [COEF_W-1:0] coef_ff [NUM_COEF];
   logic signed [COEF_W-1:0] pt [3];
   logic signed [PROD_W-1:0] prod [3][3];
   logic signed [SH_W-1:0]   sh_in [3][3];
   logic signed [SH_W-1:0]   sh_ff [3][3];
   logic signed [COEF_W-1:0] off_ff [3];
   logic                     p_valid_ff;
   logic signed [CLIP_W-1:0] sum_in [3];
   logic signed [CLIP_W-1:0] sum_ff [3];
   logic                     s_valid_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_COEF; i++) begin
         if (reset) begin
            coef_ff[i] <= '0;
         end else if (load_we && load_idx == IDX_W'(i)) begin
            coef_ff[i] <= load_value;
         end
      end
   end

   assign pt[0] = px;
   assign pt[1] = py;
   assign pt[2] = pz;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            prod[r][j]  = coef_ff[r*4+j] * pt[j];
            sh_in[r][j] = prod[r][j][PROD_W-1:FRAC_BITS];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = CLIP_W'(sh_ff[r][0]) + CLIP_W'(sh_ff[r][1]) + CLIP_W'(sh_ff[r][2])
                     + CLIP_W'(off_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= in_valid;
         s_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sh_ff  <= sh_in;
         sum_ff <= sum_in;
         for (int r = 0; r < 3; r++) begin
            off_ff[r] <= coef_ff[r*4+3];
         end
      end
   end

   assign out_valid = s_valid_ff;
   assign cx        = sum_ff[0];
   assign cy        = sum_ff[1];
   assign cw        = sum_ff[2];

endmodule

`default_nettype wire

// ===== src/pws_div.sv =====
// ============================================================================
// Perspective World To Screen Divider
// Pipelined restoring division of clip x and y by w, two quotient bits a stage.
// ============================================================================
`default_nettype none

module pws_div #(
   parameter int FRAC_BITS = 16,
   parameter int CLIP_W    = 66 - FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic signed [CLIP_W-1:0]          num_x,
   input  logic signed [CLIP_W-1:0]          num_y,
   input  logic signed [CLIP_W-1:0]          den,
   output pws_pkg::pws_ctl_type              out_ctl,
   output logic [pws_pkg::NQ_W-1:0]          quo_x,
   output logic [pws_pkg::NQ_W-1:0]          quo_y,
   output logic signed [pws_pkg::COEF_W-1:0] out_dw
);
   import pws_pkg::*;

   localparam int STEPS = 2;
   localparam int NS    = (NQ_W + STEPS - 1) / STEPS;
   localparam int DIV_W = CLIP_W + FRAC_BITS;
   localparam int TOP_W = DIV_W - NQ_W;

   logic [CLIP_W-1:0]     rem_ff [NS+1][2];
   logic [NQ_W-1:0]       q_ff   [NS+1][2];
   logic [NQ_W-1:0]       low_ff [NS+1][2];
   logic [CLIP_W-1:0]     b_ff   [NS+1];
   pws_ctl_type           ctl_ff [NS+1];
   logic signed [COEF_W-1:0] dw_ff [NS+1];

   logic [CLIP_W-1:0] a_x, a_y, b;
   logic [DIV_W-1:0]  d_x, d_y;
   logic [TOP_W-1:0]  top_x, top_y;
   logic              hi_ovf, lo_ovf;
   pws_ctl_type       ctl_in;
   logic signed [COEF_W-1:0] dw_in;

   always_comb begin
      a_x    = num_x[CLIP_W-1] ? CLIP_W'(-num_x) : CLIP_W'(num_x);
      a_y    = num_y[CLIP_W-1] ? CLIP_W'(-num_y) : CLIP_W'(num_y);
      b      = den[CLIP_W-1] ? CLIP_W'(-den) : CLIP_W'(den);
      d_x    = {a_x, {FRAC_BITS{1'b0}}};
      d_y    = {a_y, {FRAC_BITS{1'b0}}};
      top_x  = d_x[DIV_W-1:NQ_W];
      top_y  = d_y[DIV_W-1:NQ_W];
      hi_ovf = !den[CLIP_W-1] && (|den[CLIP_W-2:COEF_W-1]);
      lo_ovf = den[CLIP_W-1] && !(&den[CLIP_W-2:COEF_W-1]);
      dw_in  = hi_ovf ? 32'sh7fff_ffff : (lo_ovf ? 32'sh8000_0000 : den[COEF_W-1:0]);
      ctl_in.valid   = in_valid;
      ctl_in.w_zero  = (den == '0);
      ctl_in.dw_clip = hi_ovf || lo_ovf;
      ctl_in.neg_x   = num_x[CLIP_W-1] != den[CLIP_W-1];
      ctl_in.neg_y   = num_y[CLIP_W-1] != den[CLIP_W-1];
      ctl_in.ovf_x   = CLIP_W'(top_x) >= b;
      ctl_in.ovf_y   = CLIP_W'(top_y) >= b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (adv) begin
         ctl_ff[0] <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0][0] <= CLIP_W'(top_x);
         rem_ff[0][1] <= CLIP_W'(top_y);
         low_ff[0][0] <= d_x[NQ_W-1:0];
         low_ff[0][1] <= d_y[NQ_W-1:0];
         q_ff[0][0]   <= '0;
         q_ff[0][1]   <= '0;
         b_ff[0]      <= b;
         dw_ff[0]     <= dw_in;
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [CLIP_W-1:0] rem_in [2];
      logic [NQ_W-1:0]   q_in   [2];

      always_comb begin
         logic [CLIP_W:0] t;
         int              k;
         for (int l = 0; l < 2; l++) begin
            rem_in[l] = rem_ff[s][l];
            q_in[l]   = q_ff[s][l];
            for (int j = 0; j < STEPS; j++) begin
               k = NQ_W - 1 - s * STEPS - j;
               if (k >= 0) begin
                  t = {rem_in[l], low_ff[s][l][k]};
                  if (t >= {1'b0, b_ff[s]}) begin
                     t          = t - {1'b0, b_ff[s]};
                     q_in[l][k] = 1'b1;
                  end
                  rem_in[l] = t[CLIP_W-1:0];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s+1] <= '0;
         end else if (adv) begin
            ctl_ff[s+1] <= ctl_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s+1] <= rem_in;
            q_ff[s+1]   <= q_in;
            low_ff[s+1] <= low_ff[s];
            b_ff[s+1]   <= b_ff[s];
            dw_ff[s+1]  <= dw_ff[s];
         end
      end
   end

   assign out_ctl = ctl_ff[NS];
   assign quo_x   = q_ff[NS][0];
   assign quo_y   = q_ff[NS][1];
   assign out_dw  = dw_ff[NS];

endmodule

`default_nettype wire

// ===== src/pws_map.sv =====
// ============================================================================
// Perspective World To Screen Viewport Map
// Scales the normalized coordinates to pixels, saturates and holds the result.
// ============================================================================
`default_nettype none

module pws_map #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  pws_pkg::pws_ctl_type              in_ctl,
   input  logic [pws_pkg::NQ_W-1:0]          quo_x,
   input  logic [pws_pkg::NQ_W-1:0]          quo_y,
   input  logic signed [pws_pkg::COEF_W-1:0] in_dw,
   input  logic [pws_pkg::DIM_W-1:0]         width,
   input  logic [pws_pkg::DIM_W-1:0]         height,
   output logic                              out_valid,
   output logic signed [pws_pkg::COEF_W-1:0] screen_x,
   output logic signed [pws_pkg::COEF_W-1:0] screen_y,
   output logic signed [pws_pkg::COEF_W-1:0] depth_w,
   output logic                              w_zero,
   output logic                              clipped
);
   import pws_pkg::*;

   localparam int NDC_W  = NQ_W + 2;
   localparam int PROD_W = NDC_W + DIM_W + 1;
   localparam int SUM_W  = PROD_W + 2;

   logic [NQ_W:0]            mag_x, mag_y;
   logic signed [NDC_W-1:0]  ndc_x, ndc_y;
   logic signed [PROD_W-1:0] prod_x_in, prod_y_in, prod_x_ff, prod_y_ff;
   pws_ctl_type              ctl_ff;
   logic signed [COEF_W-1:0] dw_ff;

   logic signed [PROD_W-1:0] hx, hy;
   logic signed [SUM_W-1:0]  hx_e, hy_e, base_x, base_y, half_one, sx, sy;
   logic                     sx_hi, sx_lo, sy_hi, sy_lo;
   logic signed [COEF_W-1:0] sx_sat, sy_sat;

   logic                     valid_ff;
   logic signed [COEF_W-1:0] sx_ff, sy_ff, dw_out_ff;
   logic                     wz_ff, clip_ff;

   always_comb begin
      mag_x     = in_ctl.ovf_x ? {1'b1, {NQ_W{1'b0}}} : {1'b0, quo_x};
      mag_y     = in_ctl.ovf_y ? {1'b1, {NQ_W{1'b0}}} : {1'b0, quo_y};
      ndc_x     = in_ctl.neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
      ndc_y     = in_ctl.neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
      prod_x_in = ndc_x * $signed({1'b0, width});
      prod_y_in = ndc_y * $signed({1'b0, height});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         dw_ff     <= in_dw;
      end
   end

   always_comb begin
      hx       = prod_x_ff >>> 1;
      hy       = prod_y_ff >>> 1;
      hx_e     = {{(SUM_W-PROD_W){hx[PROD_W-1]}}, hx};
      hy_e     = {{(SUM_W-PROD_W){hy[PROD_W-1]}}, hy};
      base_x   = $signed(SUM_W'({width, {(FRAC_BITS-1){1'b0}}}));
      base_y   = $signed(SUM_W'({height, {(FRAC_BITS-1){1'b0}}}));
      half_one = $signed(SUM_W'(1) << (FRAC_BITS - 1));
      sx       = base_x + hx_e + half_one;
      sy       = base_y - (hy_e + half_one);
      sx_hi    = !sx[SUM_W-1] && (|sx[SUM_W-2:COEF_W-1]);
      sx_lo    = sx[SUM_W-1] && !(&sx[SUM_W-2:COEF_W-1]);
      sy_hi    = !sy[SUM_W-1] && (|sy[SUM_W-2:COEF_W-1]);
      sy_lo    = sy[SUM_W-1] && !(&sy[SUM_W-2:COEF_W-1]);
      sx_sat   = sx_hi ? 32'sh7fff_ffff : (sx_lo ? 32'sh8000_0000 : sx[COEF_W-1:0]);
      sy_sat   = sy_hi ? 32'sh7fff_ffff : (sy_lo ? 32'sh8000_0000 : sy[COEF_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wz_ff <= ctl_ff.w_zero;
         if (ctl_ff.w_zero) begin
            sx_ff     <= '0;
            sy_ff     <= '0;
            dw_out_ff <= '0;
            clip_ff   <= 1'b0;
         end else begin
            sx_ff     <= sx_sat;
            sy_ff     <= sy_sat;
            dw_out_ff <= dw_ff;
            clip_ff   <= sx_hi || sx_lo || sy_hi || sy_lo || ctl_ff.dw_clip;
         end
      end
   end

   assign out_valid = valid_ff;
   assign screen_x  = sx_ff;
   assign screen_y  = sy_ff;
   assign depth_w   = dw_out_ff;
   assign w_zero    = wz_ff;
   assign clipped   = clip_ff;

endmodule

`default_nettype wire

// ===== src/pws_checker.sv =====
// ============================================================================
// Perspective World To Screen Checker
// Port-level checks on flow control and zero-w results, bound to the top.
// ============================================================================
`default_nettype none

`include "perspective_world_to_screen_macros.svh"

module pws_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [pws_pkg::COEF_W-1:0] screen_x,
   input logic signed [pws_pkg::COEF_W-1:0] screen_y,
   input logic signed [pws_pkg::COEF_W-1:0] depth_w,
   input logic                              w_zero,
   input logic                              clipped
);
   import pws_pkg::*;

   `PWS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(screen_x) && $stable(screen_y) && $stable(depth_w), "response item changed while stalled")
   `PWS_ASSERT(a_wzero_out, clock, reset, rsp_valid && w_zero |-> screen_x == 0 && screen_y == 0 && depth_w == 0 && !clipped, "zero w item carries nonzero fields")
   `PWS_ASSERT(a_ready_flow, clock, reset, 1'b1 |-> req_ready == (!rsp_valid || rsp_ready), "request ready does not follow response flow")
   `PWS_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "response valid right after reset")

endmodule

bind perspective_world_to_screen pws_checker u_pws_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .screen_x  (rsp_port.screen_x),
   .screen_y  (rsp_port.screen_y),
   .depth_w   (rsp_port.depth_w),
   .w_zero    (rsp_port.w_zero),
   .clipped   (rsp_port.clipped)
);

`default_nettype wire
